FILE: design/dsw_pkg.sv
`default_nettype none
package dsw_pkg;

    localparam int DIGITS      = 8;
    localparam int W_VALUE     = 27;
    localparam int W_POS       = 3;
    localparam int W_DIGIT     = 4;
    localparam int W_IDX       = (DIGITS > 1) ? $clog2(DIGITS) : 1;
    localparam int W_CNT       = 4;
    localparam int POSITIONS   = 8;

    localparam logic [W_VALUE-1:0] VALUE_LIMIT = W_VALUE'(99999999);
    localparam logic [7:0]         GRID_BASE   = 8'hC0;

    // floor(v / 10) == (v * RECIP_10) >> RECIP_SHIFT for any v below 2^32.
    localparam logic [31:0] RECIP_10    = 32'hCCCCCCCD;
    localparam int          RECIP_SHIFT = 35;
    localparam int          W_PROD      = W_VALUE + 32;

    typedef logic [DIGITS-1:0][W_DIGIT-1:0] t_digits;

    typedef struct packed {
        logic [W_VALUE-1:0] quot;
        t_digits            digs;
        logic [W_POS-1:0]   start;
    } t_cell_data;

    function automatic logic [7:0] seg_pattern(input logic [W_DIGIT-1:0] d);
        logic [7:0] s;
        case (d)
            4'd0:    s = 8'h3f;
            4'd1:    s = 8'h06;
            4'd2:    s = 8'h5b;
            4'd3:    s = 8'h4f;
            4'd4:    s = 8'h66;
            4'd5:    s = 8'h6d;
            4'd6:    s = 8'h7d;
            4'd7:    s = 8'h07;
            4'd8:    s = 8'h7f;
            4'd9:    s = 8'h6f;
            default: s = 8'h00;
        endcase
        return s;
    endfunction

endpackage
`default_nettype wire

FILE: design/dsw_cell.sv
`default_nettype none
module dsw_cell (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_valid,
    input  dsw_pkg::t_cell_data  i_data,
    output logic                 o_ready,
    output logic                 o_valid,
    output dsw_pkg::t_cell_data  o_data,
    input  wire                  i_ready
);
    import dsw_pkg::*;

    logic [W_PROD-1:0]  prod;
    logic [W_VALUE-1:0] quot;
    logic [W_VALUE-1:0] times10;
    logic [W_VALUE-1:0] rem;
    t_cell_data         n_data;
    t_cell_data         r_data;
    logic               r_valid;

    // Peel off the low decimal digit; it enters slot 0 and older digits move up.
    always_comb begin
        prod    = {32'b0, i_data.quot} * {{W_VALUE{1'b0}}, RECIP_10};
        quot    = prod[RECIP_SHIFT +: W_VALUE];
        times10 = (quot << 3) + (quot << 1);
        rem     = i_data.quot - times10;
        n_data.quot  = quot;
        n_data.start = i_data.start;
        n_data.digs[0] = rem[W_DIGIT-1:0];
        for (int j = 1; j < DIGITS; j++) begin
            n_data.digs[j] = i_data.digs[j-1];
        end
    end

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

endmodule
`default_nettype wire

FILE: design/dsw_serializer.sv
`default_nettype none
module dsw_serializer (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_blank,
    input  wire                  i_valid,
    input  dsw_pkg::t_cell_data  i_data,
    output logic                 o_ready,
    output logic                 o_valid,
    output logic [7:0]           o_grid_address,
    output logic [7:0]           o_segment_byte,
    output logic                 o_last,
    input  wire                  i_ready
);
    import dsw_pkg::*;

    logic                r_busy;
    t_digits             r_digs;
    logic [W_IDX-1:0]    r_k;
    logic [W_POS-1:0]    r_pos;
    logic [W_CNT-1:0]    r_left;
    logic [W_IDX-1:0]    n_first;
    logic [W_CNT-1:0]    avail;
    logic [W_CNT-1:0]    room;
    logic [W_CNT-1:0]    n_left;
    logic                load;

    // Slot 0 holds the most significant digit. The last digit is never blanked.
    always_comb begin
        n_first = W_IDX'(DIGITS - 1);
        for (int j = DIGITS - 2; j >= 0; j--) begin
            if (i_data.digs[j] != '0) begin
                n_first = W_IDX'(j);
            end
        end
        if (!i_blank) begin
            n_first = '0;
        end
        avail  = W_CNT'(DIGITS) - W_CNT'(n_first);
        room   = W_CNT'(POSITIONS) - W_CNT'(i_data.start);
        n_left = (avail < room) ? avail : room;
    end

    assign o_last         = (r_left == W_CNT'(1));
    assign o_ready        = !r_busy || (i_ready && o_last);
    assign load           = i_valid && o_ready;
    assign o_valid        = r_busy;
    assign o_grid_address = GRID_BASE + {4'b0, r_pos, 1'b0};
    assign o_segment_byte = seg_pattern(r_digs[r_k]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (load) begin
            r_busy <= 1'b1;
        end else if (r_busy && i_ready && o_last) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_digs <= i_data.digs;
            r_k    <= n_first;
            r_pos  <= i_data.start;
            r_left <= n_left;
        end else if (r_busy && i_ready) begin
            r_k    <= r_k + 1'b1;
            r_pos  <= r_pos + 1'b1;
            r_left <= r_left - 1'b1;
        end
    end

endmodule
`default_nettype wire

FILE: design/decimal_to_seven_segment_writer.sv
`default_nettype none
// Path: a value's writes are presented after it passes the row of DIGITS digit cells (one
// decimal digit each, each registered) and is loaded into the write serializer.
// A value giving n writes (1 to 8) holds the serializer until its last write is taken; the
// cell row keeps taking beats meanwhile until its DIGITS cells are full. Values above
// 99999999 are taken and dropped.
// Reset: synchronous, active low; clears all valid flags and sets blanking on.
module decimal_to_seven_segment_writer (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_cfg_we,
    input  wire                          i_cfg_wdata,
    input  wire                          i_valid,
    output logic                         o_ready,
    input  wire [dsw_pkg::W_VALUE-1:0]   i_value,
    input  wire [dsw_pkg::W_POS-1:0]     i_start_position,
    output logic                         o_valid,
    input  wire                          i_ready,
    output logic [7:0]                   o_grid_address,
    output logic [7:0]                   o_segment_byte,
    output logic                         o_last
);
    import dsw_pkg::*;

    logic                  r_blank;
    logic [DIGITS:0]       valid_c;
    logic [DIGITS:0]       ready_c;
    t_cell_data            data_c [DIGITS+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blank <= 1'b1;
        end else if (i_cfg_we) begin
            r_blank <= i_cfg_wdata;
        end
    end

    assign valid_c[0]       = i_valid && (i_value <= VALUE_LIMIT);
    assign o_ready          = ready_c[0];
    assign data_c[0].quot   = i_value;
    assign data_c[0].digs   = '0;
    assign data_c[0].start  = i_start_position;

    for (genvar g = 0; g < DIGITS; g++) begin : g_cell
        dsw_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (valid_c[g]),
            .i_data  (data_c[g]),
            .o_ready (ready_c[g]),
            .o_valid (valid_c[g+1]),
            .o_data  (data_c[g+1]),
            .i_ready (ready_c[g+1])
        );
    end

    dsw_serializer u_ser (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_blank        (r_blank),
        .i_valid        (valid_c[DIGITS]),
        .i_data         (data_c[DIGITS]),
        .o_ready        (ready_c[DIGITS]),
        .o_valid        (o_valid),
        .o_grid_address (o_grid_address),
        .o_segment_byte (o_segment_byte),
        .o_last         (o_last),
        .i_ready        (i_ready)
    );

endmodule
`default_nettype wire
